// ===== rtl/core/clb_pkg.sv =====
// ----------------------------------------------------------------------------
// clb_pkg
// Shared constants and types for the cursor line edit buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package clb_pkg;

  localparam int LINE_CAP = 128;
  localparam int ADDR_W   = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;
  localparam int CNT_W    = 8;
  localparam int CHAR_W   = 8;
  localparam int MODE_W   = 3;

  localparam logic [CNT_W-1:0] LINE_CAP_C = CNT_W'(LINE_CAP);

  localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BACKSPACE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LEFT      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RIGHT     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SET       = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd5;
  localparam logic [MODE_W-1:0] MODE_READ      = 3'd6;

  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } clb_mem_req_t;

  typedef struct packed {
    logic              status;
    logic [CNT_W-1:0]  cursor;
    logic [CNT_W-1:0]  length;
    logic [CHAR_W-1:0] rchar;
  } clb_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/cursor_line_edit_buffer.sv =====
// ----------------------------------------------------------------------------
// cursor_line_edit_buffer
// One-line text edit buffer with cursor, backed by a byte-wide line RAM.
// ----------------------------------------------------------------------------
// Takes one command at a time and returns exactly one result per command.
// Insert and backspace shift the bytes from the cursor to the length. The
// longest command is an insert at the head of a line one byte short of
// full: the tail moves one byte per cycle through the single read and
// single write port of the line RAM. A read below the length waits on the
// registered RAM read; a read at or past the length returns zero without
// one. A result that finds the output register still held waits in the
// controller until it drains. The result sits in an output register, so the
// next command is taken while it waits to be drained. After reset the line
// is empty and usable at once; no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_line_edit_buffer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_mode,
  input  wire logic [7:0]  in_data_char,
  input  wire logic [7:0]  in_position,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_status,
  output logic [7:0]       out_cursor_now,
  output logic [7:0]       out_length_now,
  output logic [7:0]       out_read_char
);

  clb_pkg::clb_mem_req_t        mem_req;
  logic [clb_pkg::CHAR_W-1:0]   mem_rdata;
  logic                         res_valid;
  logic                         res_ready;
  clb_pkg::clb_result_t         res;

  logic                         out_valid_r, out_valid_nxt;
  clb_pkg::clb_result_t         out_res_r;

  clb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_valid),
    .cmd_stall (in_stall),
    .cmd_mode  (in_mode),
    .cmd_char  (in_data_char),
    .cmd_pos   (in_position),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  clb_line_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // load when the slot is empty or being drained this cycle
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_res_r.status;
  assign out_cursor_now = out_res_r.cursor;
  assign out_length_now = out_res_r.length;
  assign out_read_char  = out_res_r.rchar;

endmodule

`default_nettype wire

// ===== rtl/core/clb_line_ram.sv =====
// ----------------------------------------------------------------------------
// clb_line_ram
// Line byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module clb_line_ram (
  input  wire logic                         clk,
  input  wire clb_pkg::clb_mem_req_t        req,
  output logic [clb_pkg::CHAR_W-1:0]        rdata
);

  logic [clb_pkg::CHAR_W-1:0] mem [clb_pkg::LINE_CAP];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/clb_ctrl.sv =====
// ----------------------------------------------------------------------------
// clb_ctrl
// Command sequencer: holds cursor and length, walks the store one byte per
// cycle for insert and backspace shifts, and builds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module clb_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cmd_valid,
  output logic                               cmd_stall,
  input  wire logic [clb_pkg::MODE_W-1:0]    cmd_mode,
  input  wire logic [clb_pkg::CHAR_W-1:0]    cmd_char,
  input  wire logic [clb_pkg::CNT_W-1:0]     cmd_pos,
  output clb_pkg::clb_mem_req_t              mem_req,
  input  wire logic [clb_pkg::CHAR_W-1:0]    mem_rdata,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output clb_pkg::clb_result_t               res
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_PUT,
    ST_BSP,
    ST_RDW,
    ST_RESP
  } state_t;

  state_t                      state_r, state_nxt;
  logic [clb_pkg::CNT_W-1:0]   cursor_r, cursor_nxt;
  logic [clb_pkg::CNT_W-1:0]   length_r, length_nxt;
  logic [clb_pkg::CNT_W-1:0]   k_r, k_nxt;
  logic [clb_pkg::CHAR_W-1:0]  ch_r, ch_nxt;
  logic                        status_r, status_nxt;
  logic [clb_pkg::CHAR_W-1:0]  rchar_r, rchar_nxt;

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    length_nxt    = length_r;
    k_nxt         = k_r;
    ch_nxt        = ch_r;
    status_nxt    = status_r;
    rchar_nxt     = rchar_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = '0;
    mem_req.wdata = mem_rdata;
    mem_req.raddr = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          status_nxt = clb_pkg::STATUS_DONE;
          rchar_nxt  = '0;
          ch_nxt     = cmd_char;
          state_nxt  = ST_RESP;
          unique case (cmd_mode)
            clb_pkg::MODE_INSERT: begin
              if (length_r >= clb_pkg::LINE_CAP_C) begin
                status_nxt = clb_pkg::STATUS_REJECT;
              end else if (cursor_r == length_r) begin
                state_nxt = ST_PUT;
              end else begin
                // fetch the last byte; it moves up one place first
                mem_req.raddr = clb_pkg::ADDR_W'(length_r - 8'd1);
                k_nxt         = length_r;
                state_nxt     = ST_INS;
              end
            end
            clb_pkg::MODE_BACKSPACE: begin
              if (cursor_r == '0) begin
                status_nxt = clb_pkg::STATUS_REJECT;
              end else if (cursor_r == length_r) begin
                // no tail to move; stale byte is masked by the length
                cursor_nxt = cursor_r - 8'd1;
                length_nxt = length_r - 8'd1;
              end else begin
                mem_req.raddr = clb_pkg::ADDR_W'(cursor_r);
                k_nxt         = cursor_r;
                state_nxt     = ST_BSP;
              end
            end
            clb_pkg::MODE_LEFT: begin
              if (cursor_r == '0) begin
                status_nxt = clb_pkg::STATUS_REJECT;
              end else begin
                cursor_nxt = cursor_r - 8'd1;
              end
            end
            clb_pkg::MODE_RIGHT: begin
              if (cursor_r < length_r) begin
                cursor_nxt = cursor_r + 8'd1;
              end else begin
                status_nxt = clb_pkg::STATUS_REJECT;
              end
            end
            clb_pkg::MODE_SET: begin
              if (cmd_pos <= length_r) begin
                cursor_nxt = cmd_pos;
              end else begin
                status_nxt = clb_pkg::STATUS_REJECT;
              end
            end
            clb_pkg::MODE_CLEAR: begin
              // bytes past the length never read back, so dropping it suffices
              cursor_nxt = '0;
              length_nxt = '0;
            end
            clb_pkg::MODE_READ: begin
              if (cmd_pos < length_r) begin
                mem_req.raddr = clb_pkg::ADDR_W'(cmd_pos);
                state_nxt     = ST_RDW;
              end
            end
            default: begin
              status_nxt = clb_pkg::STATUS_REJECT;
            end
          endcase
        end
      end

      ST_INS: begin
        // store[k] <= store[k-1], walking down toward the cursor
        mem_req.we    = 1'b1;
        mem_req.waddr = clb_pkg::ADDR_W'(k_r);
        if (k_r == cursor_r + 8'd1) begin
          state_nxt = ST_PUT;
        end else begin
          mem_req.raddr = clb_pkg::ADDR_W'(k_r - 8'd2);
          k_nxt         = k_r - 8'd1;
        end
      end

      ST_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clb_pkg::ADDR_W'(cursor_r);
        mem_req.wdata = ch_r;
        cursor_nxt    = cursor_r + 8'd1;
        length_nxt    = length_r + 8'd1;
        state_nxt     = ST_RESP;
      end

      ST_BSP: begin
        // store[k-1] <= store[k], walking up toward the end
        mem_req.we    = 1'b1;
        mem_req.waddr = clb_pkg::ADDR_W'(k_r - 8'd1);
        if (k_r + 8'd1 == length_r) begin
          cursor_nxt = cursor_r - 8'd1;
          length_nxt = length_r - 8'd1;
          state_nxt  = ST_RESP;
        end else begin
          mem_req.raddr = clb_pkg::ADDR_W'(k_r + 8'd1);
          k_nxt         = k_r + 8'd1;
        end
      end

      ST_RDW: begin
        rchar_nxt = mem_rdata;
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cursor_r <= '0;
      length_r <= '0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      length_r <= length_nxt;
    end
    k_r      <= k_nxt;
    ch_r     <= ch_nxt;
    status_r <= status_nxt;
    rchar_r  <= rchar_nxt;
  end

  assign cmd_stall  = (state_r != ST_IDLE);
  assign res_valid  = (state_r == ST_RESP);
  assign res.status = status_r;
  assign res.cursor = cursor_r;
  assign res.length = length_r;
  assign res.rchar  = rchar_r;

endmodule

`default_nettype wire

// ===== rtl/core/clb_checker.sv =====
// ----------------------------------------------------------------------------
// clb_checker
// Port-level checks for the cursor line edit buffer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module clb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_status,
  input wire logic [7:0]  out_cursor_now,
  input wire logic [7:0]  out_length_now,
  input wire logic [7:0]  out_read_char
);

  // reset leaves no transaction pending on the result side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // one command in flight: an accepted transaction stalls the input next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second command taken while one is in flight");

  // reported cursor and length stay inside the line
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_length_now <= clb_pkg::LINE_CAP_C &&
                   out_cursor_now <= out_length_now))
    else $error("cursor or length out of range");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status) &&
      $stable(out_cursor_now) && $stable(out_length_now) &&
      $stable(out_read_char)))
    else $error("stalled result changed");

endmodule

bind cursor_line_edit_buffer clb_checker u_clb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_cursor_now (out_cursor_now),
  .out_length_now (out_length_now),
  .out_read_char  (out_read_char)
);

`default_nettype wire

// ===== test/tb_cursor_line_edit_buffer.sv =====
// ----------------------------------------------------------------------------
// tb_cursor_line_edit_buffer
// Self-checking testbench for the cursor line edit buffer.
// ----------------------------------------------------------------------------
// A queue of edit commands is built up front: a short directed sequence
// through every mode and the edges of the empty line, then random bursts. The bursts fill
// the line to capacity, drain it and edit it at random. A clocked driver
// feeds the commands to the block. A clocked monitor keeps a shadow copy of
// the line, the cursor and the length, predicts the reply to each accepted
// command, and checks every reply field by field. Both sides idle at random
// in the first two of three phases; the third runs with no idling.
// ----------------------------------------------------------------------------

module tb_cursor_line_edit_buffer;

  localparam logic [clb_pkg::MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam int RAND_CMDS   = 720;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = clb_pkg::LINE_CAP + 12;

  typedef struct {
    logic [2:0] mode;
    logic [7:0] ch;
    logic [7:0] pos;
  } edit_cmd_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] in_mode;
  logic [7:0] in_data_char;
  logic [7:0] in_position;
  logic       out_valid;
  logic       out_stall;
  logic       out_status;
  logic [7:0] out_cursor_now;
  logic [7:0] out_length_now;
  logic [7:0] out_read_char;

  edit_cmd_t            pending_cmds[$];
  clb_pkg::clb_result_t line_replies[$];

  // shadow of the line held by the block
  logic [7:0] line_img [clb_pkg::LINE_CAP];
  int         cur_pos;
  int         line_len;

  logic in_hs;
  int   n_total;
  int   n_cmds;
  int   n_rejects;
  int   n_full_hits;
  int   max_len;
  int   n_errors;
  int   n_cycles;

  cursor_line_edit_buffer i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_data_char   (in_data_char),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_cursor_now (out_cursor_now),
    .out_length_now (out_length_now),
    .out_read_char  (out_read_char)
  );

  always #5 clk = ~clk;

  task automatic add_cmd(input logic [2:0] mode, input logic [7:0] ch, input logic [7:0] pos);
    edit_cmd_t c;
    c.mode = mode;
    c.ch   = ch;
    c.pos  = pos;
    pending_cmds.push_back(c);
  endtask

  // mostly near the legal range, sometimes anywhere in the byte
  function automatic logic [7:0] rand_pos();
    if ($urandom_range(0, 9) < 8) return 8'($urandom_range(0, clb_pkg::LINE_CAP + 2));
    return 8'($urandom_range(0, 255));
  endfunction

  // advance the shadow line by one command and queue the reply it must give
  task automatic apply_edit(input logic [2:0] mode, input logic [7:0] ch, input logic [7:0] pos);
    clb_pkg::clb_result_t r;
    logic                 ok;
    logic [7:0]           rd;
    ok = 1'b0;
    rd = '0;
    case (mode)
      clb_pkg::MODE_INSERT: begin
        if (line_len < clb_pkg::LINE_CAP) begin
          for (int k = line_len; k > cur_pos; k--) line_img[k] = line_img[k-1];
          line_img[cur_pos] = ch;
          line_len++;
          cur_pos++;
          ok = 1'b1;
        end else begin
          n_full_hits++;
        end
      end
      clb_pkg::MODE_BACKSPACE: begin
        if (cur_pos != 0) begin
          for (int k = cur_pos; k < line_len; k++) line_img[k-1] = line_img[k];
          cur_pos--;
          line_len--;
          line_img[line_len] = '0;
          ok = 1'b1;
        end
      end
      clb_pkg::MODE_LEFT: begin
        if (cur_pos > 0) begin
          cur_pos--;
          ok = 1'b1;
        end
      end
      clb_pkg::MODE_RIGHT: begin
        if (cur_pos < line_len) begin
          cur_pos++;
          ok = 1'b1;
        end
      end
      clb_pkg::MODE_SET: begin
        if (int'(pos) <= line_len) begin
          cur_pos = pos;
          ok = 1'b1;
        end
      end
      clb_pkg::MODE_CLEAR: begin
        for (int k = 0; k < clb_pkg::LINE_CAP; k++) line_img[k] = '0;
        cur_pos  = 0;
        line_len = 0;
        ok = 1'b1;
      end
      clb_pkg::MODE_READ: begin
        if (int'(pos) < line_len) rd = line_img[pos];
        ok = 1'b1;
      end
      default: ok = 1'b0;
    endcase
    r.status = ok ? clb_pkg::STATUS_DONE : clb_pkg::STATUS_REJECT;
    r.cursor = 8'(cur_pos);
    r.length = 8'(line_len);
    r.rchar  = rd;
    line_replies.push_back(r);
    n_cmds++;
    if (!ok) n_rejects++;
    if (line_len > max_len) max_len = line_len;
  endtask

  // check the reply first, then take the new command: a reply never
  // belongs to a command accepted on the same edge
  always @(posedge clk) begin : check_and_predict
    clb_pkg::clb_result_t want;
    in_hs = rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (line_replies.size() == 0) begin
        $display("%0t: unexpected reply status=%0d cursor=%0d length=%0d char=%02h",
                 $time, out_status, out_cursor_now, out_length_now, out_read_char);
        n_errors++;
      end else begin
        want = line_replies.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, out_status);
          n_errors++;
        end
        if (out_cursor_now !== want.cursor) begin
          $display("%0t: cursor mismatch: expected %0d, actual %0d",
                   $time, want.cursor, out_cursor_now);
          n_errors++;
        end
        if (out_length_now !== want.length) begin
          $display("%0t: length mismatch: expected %0d, actual %0d",
                   $time, want.length, out_length_now);
          n_errors++;
        end
        if (out_read_char !== want.rchar) begin
          $display("%0t: read char mismatch: expected %02h, actual %02h",
                   $time, want.rchar, out_read_char);
          n_errors++;
        end
      end
    end
    if (in_hs) apply_edit(in_mode, in_data_char, in_position);
  end

  always @(negedge clk) begin : drive_cmds
    edit_cmd_t c;
    int        phase;
    int        send_idle;
    int        recv_idle;
    phase = (n_total > 0) ? (n_cmds * 3) / n_total : 0;
    case (phase)
      0:       begin send_idle = 21; recv_idle = 74; end
      1:       begin send_idle = 74; recv_idle = 21; end
      default: begin send_idle = 0;  recv_idle = 0;  end
    endcase
    if (rst_n) begin
      // hold the payload while stalled
      if (!in_valid || in_hs) begin
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          c = pending_cmds.pop_front();
          in_valid     <= 1'b1;
          in_mode      <= c.mode;
          in_data_char <= c.ch;
          in_position  <= c.pos;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d replies outstanding", $time, line_replies.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int n_rand;
    int burst;
    int kind;
    int sel;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_mode      = '0;
    in_data_char = '0;
    in_position  = '0;
    out_stall    = 1'b0;
    in_hs        = 1'b0;
    n_total      = 0;
    n_cmds       = 0;
    n_rejects    = 0;
    n_full_hits  = 0;
    max_len      = 0;
    n_errors     = 0;
    n_cycles     = 0;
    cur_pos      = 0;
    line_len     = 0;
    for (int k = 0; k < clb_pkg::LINE_CAP; k++) line_img[k] = '0;

    // directed: edges of the empty line, edits in the middle, bad cursors
    add_cmd(clb_pkg::MODE_BACKSPACE, 8'h00, 8'h00);
    add_cmd(clb_pkg::MODE_LEFT,      8'h00, 8'h00);
    add_cmd(clb_pkg::MODE_RIGHT,     8'h00, 8'h00);
    add_cmd(clb_pkg::MODE_READ,      8'h00, 8'h00);
    add_cmd(MODE_UNUSED,             8'hFF, 8'hFF);
    add_cmd(clb_pkg::MODE_INSERT,    8'h00, 8'h00);
    add_cmd(clb_pkg::MODE_INSERT,    8'hFF, 8'hFF);
    add_cmd(clb_pkg::MODE_INSERT,    8'hA5, 8'h00);
    add_cmd(clb_pkg::MODE_LEFT,      8'h00, 8'h00);
    add_cmd(clb_pkg::MODE_INSERT,    8'h5A, 8'h00);
    add_cmd(clb_pkg::MODE_RIGHT,     8'h00, 8'h00);
    add_cmd(clb_pkg::MODE_RIGHT,     8'h00, 8'h00);
    add_cmd(clb_pkg::MODE_SET,       8'h00, 8'h00);
    add_cmd(clb_pkg::MODE_BACKSPACE, 8'h00, 8'h00);
    add_cmd(clb_pkg::MODE_SET,       8'h00, 8'h02);
    add_cmd(clb_pkg::MODE_BACKSPACE, 8'h00, 8'h00);
    add_cmd(clb_pkg::MODE_SET,       8'h00, 8'(clb_pkg::LINE_CAP));
    add_cmd(clb_pkg::MODE_SET,       8'hFF, 8'hFF);
    add_cmd(clb_pkg::MODE_SET,       8'h00, 8'h03);
    add_cmd(clb_pkg::MODE_READ,      8'h00, 8'hFF);
    add_cmd(clb_pkg::MODE_READ,      8'h00, 8'h02);
    add_cmd(clb_pkg::MODE_READ,      8'h00, 8'h03);
    add_cmd(clb_pkg::MODE_CLEAR,     8'h00, 8'h00);
    add_cmd(clb_pkg::MODE_CLEAR,     8'hFF, 8'hFF);
    add_cmd(clb_pkg::MODE_INSERT,    8'h55, 8'hAA);

    // random bursts: fill past capacity, drain, clear, or edit at random
    n_rand = 0;
    while (n_rand < RAND_CMDS) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        burst = $urandom_range(clb_pkg::LINE_CAP + 2, clb_pkg::LINE_CAP + 12);
        for (int i = 0; i < burst; i++) begin
          if ($urandom_range(0, 9) == 0)
            add_cmd(clb_pkg::MODE_SET, 8'($urandom), rand_pos());
          else if ($urandom_range(0, 9) == 0)
            add_cmd(clb_pkg::MODE_READ, 8'($urandom), rand_pos());
          else
            add_cmd(clb_pkg::MODE_INSERT, 8'($urandom), 8'($urandom));
        end
      end else if (kind < 5) begin
        burst = $urandom_range(40, clb_pkg::LINE_CAP);
        for (int i = 0; i < burst; i++) begin
          if ($urandom_range(0, 3) == 0)
            add_cmd(clb_pkg::MODE_SET, 8'($urandom), rand_pos());
          else
            add_cmd(clb_pkg::MODE_BACKSPACE, 8'($urandom), 8'($urandom));
        end
      end else if (kind == 5) begin
        burst = 1;
        add_cmd(clb_pkg::MODE_CLEAR, 8'($urandom), 8'($urandom));
      end else begin
        burst = $urandom_range(20, 60);
        for (int i = 0; i < burst; i++) begin
          sel = $urandom_range(0, 99);
          if (sel < 30)
            add_cmd(clb_pkg::MODE_INSERT,    8'($urandom), 8'($urandom));
          else if (sel < 45)
            add_cmd(clb_pkg::MODE_BACKSPACE, 8'($urandom), 8'($urandom));
          else if (sel < 55)
            add_cmd(clb_pkg::MODE_LEFT,      8'($urandom), 8'($urandom));
          else if (sel < 65)
            add_cmd(clb_pkg::MODE_RIGHT,     8'($urandom), 8'($urandom));
          else if (sel < 75)
            add_cmd(clb_pkg::MODE_SET,       8'($urandom), rand_pos());
          else if (sel < 95)
            add_cmd(clb_pkg::MODE_READ,      8'($urandom), rand_pos());
          else if (sel < 97)
            add_cmd(clb_pkg::MODE_CLEAR,     8'($urandom), 8'($urandom));
          else
            add_cmd(MODE_UNUSED,             8'($urandom), 8'($urandom));
        end
      end
      n_rand += burst;
    end
    n_total = pending_cmds.size();

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (line_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (line_replies.size() != 0) begin
      $display("%0t: %0d replies never arrived", $time, line_replies.size());
      n_errors++;
    end

    $display("Ran %0d edit commands, %0d rejected, %0d inserts refused on a full line.",
             n_cmds, n_rejects, n_full_hits);
    $display("Longest line reached %0d of %0d bytes; %0d mismatches.",
             max_len, clb_pkg::LINE_CAP, n_errors);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
